>>> src/hcbd_pkg.sv
package hcbd_pkg;

  // Default width of the chunk size and payload counters.
  localparam int unsigned SizeBitsDef = 32;

  // One result: payload marker, payload byte and the two sticky flags.
  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       error_flag;
    logic       last_chunk_seen;
  } res_t;

endpackage

>>> src/hcbd_core.sv
module hcbd_core #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SizeBitsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  logic [7:0]       data_byte_i,
  output hcbd_pkg::res_t   res_o
);
  import hcbd_pkg::*;

  localparam logic [7:0] ByteCr = 8'h0D;
  localparam logic [7:0] ByteLf = 8'h0A;

  typedef enum logic [1:0] {
    MODE_HEX      = 2'd0,
    MODE_HEX_END  = 2'd1,
    MODE_BODY     = 2'd2,
    MODE_BODY_END = 2'd3
  } mode_e;

  mode_e                mode_q, mode_d;
  logic                 pend_q, pend_d;
  logic                 first_cr_q, first_cr_d;
  logic                 digit_seen_q, digit_seen_d;
  logic [SIZE_BITS-1:0] size_q, size_d;
  logic [SIZE_BITS-1:0] bread_q, bread_d;
  logic                 err_q, err_d;
  logic                 zero_q, zero_d;

  logic                 is_hex;
  logic [3:0]           hex_val;
  logic                 le_pend_in, le_first_in;
  logic                 le_err, le_done, le_pend, le_first;
  logic [SIZE_BITS-1:0] bread_inc;

  // Decode one ASCII hex digit.
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (data_byte_i >= 8'h30 && data_byte_i <= 8'h39) begin
      hex_val = 4'(data_byte_i - 8'h30);
    end else if (data_byte_i >= 8'h41 && data_byte_i <= 8'h46) begin
      hex_val = 4'(data_byte_i - 8'h37);
    end else if (data_byte_i >= 8'h61 && data_byte_i <= 8'h66) begin
      hex_val = 4'(data_byte_i - 8'h57);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Line-end checker: a payload that ran out restarts the pair from scratch.
  always_comb begin
    le_pend_in  = (mode_q == MODE_BODY) ? 1'b0 : pend_q;
    le_first_in = (mode_q == MODE_BODY) ? 1'b0 : first_cr_q;
    le_done     = le_pend_in && le_first_in && (data_byte_i == ByteLf);
    le_err      = !((data_byte_i == ByteCr) || (data_byte_i == ByteLf)) ||
                  (le_pend_in && !le_done);
    le_pend     = !le_pend_in;
    le_first    = !le_pend_in && (data_byte_i == ByteCr);
  end

  assign bread_inc = bread_q + SIZE_BITS'(1);

  always_comb begin
    mode_d       = mode_q;
    pend_d       = pend_q;
    first_cr_d   = first_cr_q;
    digit_seen_d = digit_seen_q;
    size_d       = size_q;
    bread_d      = bread_q;
    err_d        = err_q;
    zero_d       = zero_q;
    res_o.body_valid = 1'b0;
    res_o.body_byte  = 8'd0;

    if (!err_q) begin
      case (mode_q)
        MODE_HEX: begin
          if (is_hex) begin
            if (size_q[SIZE_BITS-1 -: 4] != 4'd0) begin
              err_d = 1'b1;
            end else begin
              size_d       = {size_q[SIZE_BITS-5:0], hex_val};
              digit_seen_d = 1'b1;
            end
          end else if (data_byte_i == ByteCr) begin
            if (!digit_seen_q) begin
              err_d = 1'b1;
            end else begin
              if (size_q == '0) zero_d = 1'b1;
              bread_d      = '0;
              digit_seen_d = 1'b0;
              pend_d       = 1'b1;
              first_cr_d   = 1'b1;
              mode_d       = MODE_HEX_END;
            end
          end else begin
            err_d = 1'b1;
          end
        end
        MODE_HEX_END: begin
          if (le_err) begin
            err_d = 1'b1;
          end else begin
            pend_d     = le_pend;
            first_cr_d = le_first;
            if (le_done) mode_d = (size_q == '0) ? MODE_BODY_END : MODE_BODY;
          end
        end
        MODE_BODY: begin
          if (bread_q < size_q) begin
            res_o.body_valid = 1'b1;
            res_o.body_byte  = data_byte_i;
            bread_d          = bread_inc;
            if (bread_inc == size_q) begin
              pend_d     = 1'b0;
              first_cr_d = 1'b0;
              mode_d     = MODE_BODY_END;
            end
          end else begin
            mode_d = MODE_BODY_END;
            if (le_err) begin
              err_d = 1'b1;
            end else begin
              pend_d     = le_pend;
              first_cr_d = le_first;
              if (le_done) begin
                size_d = '0;
                mode_d = MODE_HEX;
              end
            end
          end
        end
        MODE_BODY_END: begin
          if (le_err) begin
            err_d = 1'b1;
          end else begin
            pend_d     = le_pend;
            first_cr_d = le_first;
            if (le_done) begin
              size_d = '0;
              mode_d = MODE_HEX;
            end
          end
        end
        default: begin
          err_d = 1'b1;
        end
      endcase
    end

    res_o.error_flag      = err_d;
    res_o.last_chunk_seen = zero_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_HEX;
      pend_q       <= 1'b0;
      first_cr_q   <= 1'b0;
      digit_seen_q <= 1'b0;
      size_q       <= '0;
      bread_q      <= '0;
      err_q        <= 1'b0;
      zero_q       <= 1'b0;
    end else if (step_en_i) begin
      mode_q       <= mode_d;
      pend_q       <= pend_d;
      first_cr_q   <= first_cr_d;
      digit_seen_q <= digit_seen_d;
      size_q       <= size_d;
      bread_q      <= bread_d;
      err_q        <= err_d;
      zero_q       <= zero_d;
    end
  end

endmodule

>>> src/http_chunked_body_decoder.sv
// Decoder for the body of an HTTP chunked transfer stream, one raw byte per
// request. Each input byte yields exactly one result: the tuser bit marks a
// payload byte, tdata carries that byte (zero otherwise) together with a
// sticky framing-error flag and a sticky flag that a zero-size chunk line has
// been read. Size lines must be plain hex digits closed by CR LF; chunk
// extensions, trailers, empty sizes, sizes that overflow SIZE_BITS and any
// stray byte where CR or LF belongs set the error, after which every byte is
// dropped from decoding. The block takes one byte every cycle while the output
// is not stalled: a byte is held in the input register, decoded by the state
// update as it moves on, and its result is held in the output register. The
// throughput is set by the loop through the chunk size and payload counters.
// When the output is stalled the input register still takes one more byte
// before tready drops.
module http_chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = hcbd_pkg::SizeBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input bytes
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  // Results
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] body_byte, [8] error_flag,
                                        // [9] last_chunk_seen, [15:10] zero
  output logic        m_axis_tuser_o    // [0] body_valid
);
  import hcbd_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  res_t       out_q;
  res_t       step_res;
  logic       s_accept;
  logic       advance;

  // Move the held byte into the result register when that register is free
  // or being drained this cycle.
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  hcbd_core #(
    .SIZE_BITS(SIZE_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (advance),
    .data_byte_i(in_byte_q),
    .res_o      (step_res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold until replaced.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (advance) begin
      out_q <= step_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.body_valid;
  assign m_axis_tdata_o  = {6'd0, out_q.last_chunk_seen, out_q.error_flag,
                            out_q.body_byte};

  // A payload byte is never reported together with a framing error.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.body_valid && out_q.error_flag))
    else $error("payload byte marked valid after a framing error");

  // An empty result register always lets a new byte in.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> s_axis_tready_o)
    else $error("input stalled while result register is empty");

  // Once a delivered result shows the error, every later result shows it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_axis_tready_i && out_q.error_flag)
      |=> (!out_valid_q || out_q.error_flag))
    else $error("sticky error flag cleared");

  // The last-chunk flag is sticky as well.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && m_axis_tready_i && out_q.last_chunk_seen)
      |=> (!out_valid_q || out_q.last_chunk_seen))
    else $error("sticky last-chunk flag cleared");

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SizeBits = hcbd_pkg::SizeBitsDef;
  localparam logic [7:0]  AsciiCr  = 8'h0D;
  localparam logic [7:0]  AsciiLf  = 8'h0A;
  localparam int unsigned MaxShown = 100;

  // Decoder modes, in the order the chunk grammar walks through them.
  typedef enum logic [1:0] {
    MODE_SIZE,
    MODE_SIZE_EOL,
    MODE_DATA,
    MODE_DATA_EOL
  } parse_mode_e;

  // Framing fault that closes the run; the error is sticky, so only one fits.
  typedef enum int unsigned {
    FAULT_EMPTY_SIZE,
    FAULT_OVERSIZE,
    FAULT_BAD_SIZE_CHAR,
    FAULT_SIZE_NO_LF,
    FAULT_DATA_STRAY,
    FAULT_DATA_LF_FIRST,
    FAULT_DATA_CR_CR
  } fault_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] body_byte, [8] error_flag,
                                       // [9] last_chunk_seen, [15:10] zero
  logic        m_axis_tuser;           // [0] body_valid

  http_chunked_body_decoder uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // Stream bytes waiting for the driver, and decoded results waiting for the DUT.
  logic [7:0]       stream_q[$];
  hcbd_pkg::res_t   decoded_q[$];

  int unsigned src_idle_pct  = 26;
  int unsigned sink_idle_pct = 54;
  int unsigned queued_count  = 0;
  int unsigned sent_count    = 0;
  int unsigned result_count  = 0;
  int unsigned payload_count = 0;
  int unsigned chunk_count   = 0;
  int unsigned mismatches    = 0;
  fault_e      closing_fault;

  // Shadow decoder state, same reset values as the DUT.
  parse_mode_e         sh_mode      = MODE_SIZE;
  logic                sh_eol_held  = 1'b0;
  logic                sh_eol_cr    = 1'b0;
  logic [3:0]          sh_digits    = 4'd0;
  logic [SizeBits-1:0] sh_size      = '0;
  logic [SizeBits-1:0] sh_count     = '0;
  logic                sh_error     = 1'b0;
  logic                sh_last      = 1'b0;

  function automatic int hex_nibble(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    return -1;
  endfunction

  // Consume one byte of a CR LF pair; return 1 once the pair is complete.
  function automatic bit take_line_end(logic [7:0] b);
    if (b != AsciiCr && b != AsciiLf) begin
      sh_error = 1'b1;
      return 1'b0;
    end
    if (!sh_eol_held) begin
      sh_eol_held = 1'b1;
      sh_eol_cr   = (b == AsciiCr);
      return 1'b0;
    end
    if (sh_eol_cr && b == AsciiLf) begin
      sh_eol_held = 1'b0;
      sh_eol_cr   = 1'b0;
      return 1'b1;
    end
    sh_error = 1'b1;
    return 1'b0;
  endfunction

  // Advance the shadow decoder by one stream byte and return its result.
  function automatic hcbd_pkg::res_t decode_stream_byte(logic [7:0] b);
    hcbd_pkg::res_t r;
    int             nib;
    r   = '0;
    nib = hex_nibble(b);
    if (!sh_error) begin
      case (sh_mode)
        MODE_SIZE: begin
          if (nib >= 0) begin
            if (sh_size[SizeBits-1 -: 4] != 4'd0) begin
              sh_error = 1'b1;
            end else begin
              sh_size = {sh_size[SizeBits-5:0], nib[3:0]};
              if (sh_digits != 4'hF) sh_digits = sh_digits + 4'd1;
            end
          end else if (b == AsciiCr) begin
            if (sh_digits == 4'd0) begin
              sh_error = 1'b1;
            end else begin
              if (sh_size == '0) sh_last = 1'b1;
              sh_count    = '0;
              sh_digits   = 4'd0;
              sh_eol_held = 1'b1;
              sh_eol_cr   = 1'b1;
              sh_mode     = MODE_SIZE_EOL;
            end
          end else begin
            sh_error = 1'b1;
          end
        end
        MODE_SIZE_EOL: begin
          if (take_line_end(b)) begin
            if (sh_size == '0) sh_mode = MODE_DATA_EOL;
            else sh_mode = MODE_DATA;
          end
        end
        MODE_DATA: begin
          if (sh_count < sh_size) begin
            r.body_valid = 1'b1;
            r.body_byte  = b;
            sh_count     = sh_count + 1'b1;
            if (sh_count == sh_size) begin
              sh_eol_held = 1'b0;
              sh_eol_cr   = 1'b0;
              sh_mode     = MODE_DATA_EOL;
            end
          end else begin
            sh_eol_held = 1'b0;
            sh_eol_cr   = 1'b0;
            sh_mode     = MODE_DATA_EOL;
            if (take_line_end(b)) begin
              sh_size = '0;
              sh_mode = MODE_SIZE;
            end
          end
        end
        default: begin
          if (take_line_end(b)) begin
            sh_size = '0;
            sh_mode = MODE_SIZE;
          end
        end
      endcase
    end
    r.error_flag      = sh_error;
    r.last_chunk_seen = sh_last;
    return r;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (mismatches < MaxShown)
      $display("%0t: result %0d %s: got 0x%0h, want 0x%0h", $time, result_count, what,
               got, want);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------

  task automatic push_byte(logic [7:0] b);
    stream_q.push_back(b);
    queued_count++;
  endtask

  // Push one hex digit, upper or lower case at random.
  task automatic push_hex(logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) c = "0" + nib;
    else if ($urandom_range(0, 1) == 0) c = "A" + (nib - 4'd10);
    else c = "a" + (nib - 4'd10);
    push_byte(c);
  endtask

  // Push the digits of a size, with leading zeros ahead of it.
  task automatic push_size_digits(int unsigned size, int unsigned zeros);
    int unsigned n;
    repeat (zeros) push_hex(4'd0);
    n = 1;
    while (n < 8 && (size >> (4 * n)) != 0) n++;
    for (int i = int'(n) - 1; i >= 0; i--) push_hex(4'((size >> (4 * i)) & 32'hF));
  endtask

  task automatic push_crlf();
    push_byte(AsciiCr);
    push_byte(AsciiLf);
  endtask

  // Payload bytes lean on CR and LF now and then to test that they pass through.
  function automatic logic [7:0] pick_payload_byte();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 6) return AsciiCr;
    if (r < 12) return AsciiLf;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic push_chunk(int unsigned size, int unsigned zeros);
    push_size_digits(size, zeros);
    push_crlf();
    repeat (size) push_byte(pick_payload_byte());
    push_crlf();
    chunk_count++;
  endtask

  // Append well-formed chunks of random size until the target count is queued.
  task automatic add_random_chunks(int unsigned target);
    int unsigned size;
    int unsigned zeros;
    int unsigned r;
    while (queued_count < target) begin
      r = $urandom_range(0, 99);
      if (r < 6) size = 0;
      else if (r < 90) size = $urandom_range(1, 24);
      else size = $urandom_range(25, 70);
      r = $urandom_range(0, 99);
      if (r < 80) zeros = 0;
      else if (r < 95) zeros = $urandom_range(1, 3);
      else zeros = $urandom_range(12, 18);
      push_chunk(size, zeros);
    end
  endtask

  // Close the stream with one framing fault, then noise that must be ignored.
  task automatic add_closing_fault();
    logic [7:0] b;
    int unsigned size;
    closing_fault = fault_e'($urandom_range(0, 6));
    size = $urandom_range(1, 8);
    case (closing_fault)
      FAULT_EMPTY_SIZE: push_byte(AsciiCr);
      FAULT_OVERSIZE: begin
        repeat ($urandom_range(0, 3)) push_hex(4'd0);
        push_hex(4'($urandom_range(1, 15)));
        repeat (8) push_hex(4'($urandom_range(0, 15)));
      end
      FAULT_BAD_SIZE_CHAR: begin
        push_size_digits(size, 0);
        do b = 8'($urandom_range(0, 255));
        while (hex_nibble(b) >= 0 || b == AsciiCr);
        push_byte(b);
      end
      FAULT_SIZE_NO_LF: begin
        push_size_digits(size, 0);
        push_byte(AsciiCr);
        do b = 8'($urandom_range(0, 255));
        while (b == AsciiLf);
        push_byte(b);
      end
      default: begin
        push_size_digits(size, 0);
        push_crlf();
        repeat (size) push_byte(pick_payload_byte());
        if (closing_fault == FAULT_DATA_STRAY) begin
          do b = 8'($urandom_range(0, 255));
          while (b == AsciiCr || b == AsciiLf);
          push_byte(b);
        end else if (closing_fault == FAULT_DATA_LF_FIRST) begin
          push_byte(AsciiLf);
          push_byte(($urandom_range(0, 1) == 0) ? AsciiCr : AsciiLf);
        end else begin
          push_byte(AsciiCr);
          push_byte(AsciiCr);
        end
      end
    endcase
    repeat (30) push_byte(8'($urandom_range(0, 255)));
  endtask

  // Hold until every queued request is accepted and every result checked.
  task automatic wait_drained();
    while (sent_count != queued_count || decoded_q.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer the next byte, predict on each accepted request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        decoded_q.push_back(decode_stream_byte(s_axis_tdata));
        sent_count++;
      end
      // Move to a new byte only when the current one is gone or none is offered.
      if (!s_axis_tvalid || s_axis_tready) begin
        if (stream_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          s_axis_tdata  <= stream_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: stall at random, compare each accepted result with the oldest one
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    hcbd_pkg::res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (decoded_q.size() == 0) begin
          report_mismatch("unexpected result", m_axis_tdata, 0);
        end else begin
          want = decoded_q.pop_front();
          if (want.body_valid) payload_count++;
          if (m_axis_tuser != want.body_valid)
            report_mismatch("body_valid", m_axis_tuser, want.body_valid);
          if (m_axis_tdata[7:0] != want.body_byte)
            report_mismatch("body_byte", m_axis_tdata[7:0], want.body_byte);
          if (m_axis_tdata[8] != want.error_flag)
            report_mismatch("error_flag", m_axis_tdata[8], want.error_flag);
          if (m_axis_tdata[9] != want.last_chunk_seen)
            report_mismatch("last_chunk_seen", m_axis_tdata[9], want.last_chunk_seen);
          if (m_axis_tdata[15:10] != 6'd0)
            report_mismatch("tdata padding", m_axis_tdata[15:10], 0);
        end
      end
      m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, three idling phases, closing fault, drain and verdict
  // ---------------------------------------------------------------------------
  initial begin
    // Directed opening: payload extremes, leading zeros with a CR inside the
    // payload, then the zero-size terminating chunk.
    push_chunk(2, 0);
    stream_q[3] = 8'h00;
    stream_q[4] = 8'hFF;
    push_chunk(1, 4);
    stream_q[queued_count - 3] = AsciiCr;
    push_chunk(0, 0);
    add_random_chunks(185);

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Swap the idling of the two sides, then run both at full rate.
    wait_drained();
    src_idle_pct  = 54;
    sink_idle_pct = 26;
    add_random_chunks(370);
    wait_drained();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    add_random_chunks(500);
    add_closing_fault();

    wait_drained();
    // Allow for the input and output registers so any stray result is caught.
    repeat (8) @(posedge clk_i);

    $display("Decoded %0d stream bytes in %0d chunks, %0d of them payload.",
             sent_count, chunk_count, payload_count);
    $display("Stream closed with fault %s; %0d mismatches.", closing_fault.name(),
             mismatches);
    if (mismatches == 0) begin
      $display("http_chunked_body_decoder test passed");
    end else begin
      $display("http_chunked_body_decoder test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d of %0d bytes sent, %0d results pending.", sent_count,
             queued_count, decoded_q.size());
    $display("http_chunked_body_decoder test failed");
    $finish;
  end

endmodule
